FILE: hw/rtl/satl_pkg.sv
// types and constants shared by the set-associative tag lookup block
// no dependencies
package satl_pkg;

  localparam int CNT_W    = 32;
  localparam int ADDR_W   = 32;
  localparam int EV_TAG_W = 26;
  localparam int LFSR_W   = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FETCH = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic                writeback;
    logic [EV_TAG_W-1:0] evicted_tag;
    logic [CNT_W-1:0]    read_hit_count;
    logic [CNT_W-1:0]    read_miss_count;
    logic [CNT_W-1:0]    write_hit_count;
    logic [CNT_W-1:0]    write_miss_count;
    logic [CNT_W-1:0]    memory_access_count;
  } res_t;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SPLIT   = 8'b0000_0100,
    ST_TAG_RD  = 8'b0000_1000,
    ST_TAG_CMP = 8'b0001_0000,
    ST_VIC_DIV = 8'b0010_0000,
    ST_VIC_RD  = 8'b0100_0000,
    ST_VIC_CHK = 8'b1000_0000
  } state_e;

  // fibonacci lfsr, taps 16,14,13,11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

FILE: hw/rtl/satl_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/satl_div.sv
// divider by one of two constants: reciprocal multiply, multiply back, subtract
// one shared multiplier, used for the reciprocal and for the multiply back; no dependencies
module satl_div #(
  parameter int DW    = 32,
  parameter int RW    = 7,
  parameter int DIV_A = 64,
  parameter int DIV_B = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          sel_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [RW-1:0] remainder_o
);

  // reciprocal is 2**DW plus the low part kept here
  localparam int ShA = $clog2(DIV_A);
  localparam int ShB = $clog2(DIV_B);
  localparam logic [63:0] MagA = ((64'd1 << (DW + ShA)) + 64'(DIV_A) - 64'd1) / 64'(DIV_A);
  localparam logic [63:0] MagB = ((64'd1 << (DW + ShB)) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);
  localparam logic [DW-1:0] MloA = MagA[DW-1:0];
  localparam logic [DW-1:0] MloB = MagB[DW-1:0];

  logic [3:0]      phase_q;
  logic            done_q;
  logic            sel_q;
  logic [DW-1:0]   dvd_q;
  logic [2*DW-1:0] prod_q;
  logic [DW-1:0]   quo_q;
  logic [RW-1:0]   rem_q;
  logic [DW-1:0]   mul_a;
  logic [DW-1:0]   mul_b;
  logic [2*DW-1:0] mul_p;
  logic [2*DW:0]   sum;
  logic [DW-1:0]   quo_a;
  logic [DW-1:0]   quo_b;

  // shared multiplier: reciprocal first, then quotient times divisor
  assign mul_a = phase_q[0] ? dvd_q : quo_q;
  assign mul_b = phase_q[0] ? (sel_q ? MloB : MloA)
                            : (sel_q ? DW'(DIV_B) : DW'(DIV_A));
  assign mul_p = {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};
  assign sum   = {1'b0, prod_q} + {1'b0, dvd_q, {DW{1'b0}}};
  assign quo_a = DW'(sum >> (DW + ShA));
  assign quo_b = DW'(sum >> (DW + ShB));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= phase_q[3];
      if (start_i) begin
        phase_q <= 4'b0001;
      end else begin
        phase_q <= {phase_q[2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      sel_q <= sel_i;
    end
    if (phase_q[0] || phase_q[2]) begin
      prod_q <= mul_p;
    end
    if (phase_q[1]) begin
      quo_q <= sel_q ? quo_b : quo_a;
    end
    if (phase_q[3]) begin
      rem_q <= RW'(dvd_q - prod_q[DW-1:0]);
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: hw/rtl/set_assoc_cache_tag_lookup.sv
// top level of the set-associative tag lookup with random replacement
// depends on satl_pkg, satl_ram, satl_div
//
// One access is taken when start is high and busy is low, and its result is shown
// for exactly one cycle with res_valid_o; the receiver cannot stall it. After reset
// the tag ram is cleared with busy high, one line per cycle, over all NUM_SETS*WAYS
// lines. The address is split into set and tag by a shared constant divider (reciprocal
// multiply, multiply back, subtract), then the ways of the set are read and compared
// one at a time, each read in ST_TAG_RD and compared in ST_TAG_CMP; the first hit ends
// the lookup. A miss runs the divider again to pick the victim way from the lfsr. The
// result strobe comes in the first cycle with busy low, so the next access can be taken
// in that cycle. The lookup is sequential, as the divider is shared and the ram has one
// read port.
module set_assoc_cache_tag_lookup #(
  parameter int NUM_SETS  = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  satl_pkg::req_t  req_i,
  output logic            res_valid_o,
  output satl_pkg::res_t  res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i
);

  localparam int DivW   = satl_pkg::ADDR_W;
  localparam int MaxDvs = NUM_SETS > WAYS ? NUM_SETS : WAYS;
  localparam int RemW   = $clog2(MaxDvs + 1);
  localparam int SetW   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int WayW   = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int Lines  = NUM_SETS * WAYS;
  localparam int LineW  = Lines > 1 ? $clog2(Lines) : 1;
  localparam int TagW   = ADDR_BITS;
  localparam int EntW   = TagW + 2;
  localparam int EvW    = satl_pkg::EV_TAG_W;
  localparam int CntW   = satl_pkg::CNT_W;
  localparam int LfsrW  = satl_pkg::LFSR_W;

  satl_pkg::state_e state_q, state_d;

  logic [LineW-1:0] clr_q, clr_d;
  logic [SetW-1:0]  set_q, set_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [WayW-1:0]  way_q, way_d;
  logic             is_wr_q, is_wr_d;
  logic             wb_mode_q;
  logic [LfsrW-1:0] lfsr_q, lfsr_d, lfsr_nxt;

  logic [CntW-1:0] rd_hit_q, rd_hit_d;
  logic [CntW-1:0] rd_miss_q, rd_miss_d;
  logic [CntW-1:0] wr_hit_q, wr_hit_d;
  logic [CntW-1:0] wr_miss_q, wr_miss_d;
  logic [CntW-1:0] mem_q, mem_d;

  logic            res_valid_q, res_valid_d;
  logic            res_hit_q, res_hit_d;
  logic            res_wb_q, res_wb_d;
  logic [EvW-1:0]  res_ev_q, res_ev_d;

  logic             div_start;
  logic             div_sel;
  logic [DivW-1:0]  div_dividend;
  logic             div_done;
  logic [DivW-1:0]  div_quo;
  logic [RemW-1:0]  div_rem;

  logic             ram_we;
  logic [LineW-1:0] ram_waddr;
  logic [EntW-1:0]  ram_wdata;
  logic [LineW-1:0] line_addr;
  logic [EntW-1:0]  rd_ent;
  logic             rd_valid;
  logic             rd_dirty;
  logic [TagW-1:0]  rd_tag;
  logic             tag_match;

  assign line_addr = LineW'(set_q) * LineW'(WAYS) + LineW'(way_q);
  assign rd_valid  = rd_ent[EntW-1];
  assign rd_dirty  = rd_ent[EntW-2];
  assign rd_tag    = rd_ent[TagW-1:0];
  assign tag_match = rd_valid && (rd_tag == tag_q);
  assign lfsr_nxt  = satl_pkg::lfsr_next(lfsr_q);

  satl_div #(
    .DW    (DivW),
    .RW    (RemW),
    .DIV_A (NUM_SETS),
    .DIV_B (WAYS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .sel_i       (div_sel),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  satl_ram #(
    .WIDTH (EntW),
    .DEPTH (Lines)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (line_addr),
    .rdata_o (rd_ent)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    set_d        = set_q;
    tag_d        = tag_q;
    way_d        = way_q;
    is_wr_d      = is_wr_q;
    lfsr_d       = lfsr_q;
    rd_hit_d     = rd_hit_q;
    rd_miss_d    = rd_miss_q;
    wr_hit_d     = wr_hit_q;
    wr_miss_d    = wr_miss_q;
    mem_d        = mem_q;
    res_valid_d  = 1'b0;
    res_hit_d    = res_hit_q;
    res_wb_d     = res_wb_q;
    res_ev_d     = res_ev_q;
    div_start    = 1'b0;
    div_sel      = 1'b0;
    div_dividend = DivW'(req_i.address[ADDR_BITS-1:0]);
    ram_we       = 1'b0;
    ram_waddr    = line_addr;
    ram_wdata    = '0;

    case (state_q)
      satl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LineW'(Lines - 1)) begin
          state_d = satl_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + LineW'(1);
        end
      end
      satl_pkg::ST_IDLE: begin
        if (start) begin
          div_start = 1'b1;
          is_wr_d   = (req_i.action == satl_pkg::ACT_WRITE);
          state_d   = satl_pkg::ST_SPLIT;
        end
      end
      satl_pkg::ST_SPLIT: begin
        if (div_done) begin
          set_d   = div_rem[SetW-1:0];
          tag_d   = div_quo[TagW-1:0];
          way_d   = '0;
          state_d = satl_pkg::ST_TAG_RD;
        end
      end
      satl_pkg::ST_TAG_RD: begin
        state_d = satl_pkg::ST_TAG_CMP;
      end
      satl_pkg::ST_TAG_CMP: begin
        if (tag_match) begin
          if (is_wr_q && wb_mode_q) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, 1'b1, tag_q};
          end
          if (is_wr_q) begin
            wr_hit_d = wr_hit_q + CntW'(1);
          end else begin
            rd_hit_d = rd_hit_q + CntW'(1);
          end
          res_hit_d   = 1'b1;
          res_wb_d    = 1'b0;
          res_ev_d    = '0;
          res_valid_d = 1'b1;
          state_d     = satl_pkg::ST_IDLE;
        end else if (way_q == WayW'(WAYS - 1)) begin
          lfsr_d       = lfsr_nxt;
          div_start    = 1'b1;
          div_sel      = 1'b1;
          div_dividend = DivW'(lfsr_nxt);
          state_d      = satl_pkg::ST_VIC_DIV;
        end else begin
          way_d   = way_q + WayW'(1);
          state_d = satl_pkg::ST_TAG_RD;
        end
      end
      satl_pkg::ST_VIC_DIV: begin
        if (div_done) begin
          way_d   = div_rem[WayW-1:0];
          state_d = satl_pkg::ST_VIC_RD;
        end
      end
      satl_pkg::ST_VIC_RD: begin
        state_d = satl_pkg::ST_VIC_CHK;
      end
      satl_pkg::ST_VIC_CHK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, is_wr_q && wb_mode_q, tag_q};
        if (is_wr_q) begin
          wr_miss_d = wr_miss_q + CntW'(1);
        end else begin
          rd_miss_d = rd_miss_q + CntW'(1);
        end
        mem_d       = mem_q + CntW'(1);
        res_hit_d   = 1'b0;
        res_wb_d    = wb_mode_q && rd_dirty;
        res_ev_d    = (wb_mode_q && rd_dirty) ? EvW'(rd_tag) : '0;
        res_valid_d = 1'b1;
        state_d     = satl_pkg::ST_IDLE;
      end
      default: begin
        state_d = satl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= satl_pkg::ST_CLEAR;
      clr_q       <= '0;
      wb_mode_q   <= 1'b1;
      lfsr_q      <= satl_pkg::LFSR_SEED;
      rd_hit_q    <= '0;
      rd_miss_q   <= '0;
      wr_hit_q    <= '0;
      wr_miss_q   <= '0;
      mem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lfsr_q      <= lfsr_d;
      rd_hit_q    <= rd_hit_d;
      rd_miss_q   <= rd_miss_d;
      wr_hit_q    <= wr_hit_d;
      wr_miss_q   <= wr_miss_d;
      mem_q       <= mem_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        wb_mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    set_q     <= set_d;
    tag_q     <= tag_d;
    way_q     <= way_d;
    is_wr_q   <= is_wr_d;
    res_hit_q <= res_hit_d;
    res_wb_q  <= res_wb_d;
    res_ev_q  <= res_ev_d;
  end

  assign busy        = (state_q != satl_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;

  always_comb begin
    res_o.hit                 = res_hit_q;
    res_o.writeback           = res_wb_q;
    res_o.evicted_tag         = res_ev_q;
    res_o.read_hit_count      = rd_hit_q;
    res_o.read_miss_count     = rd_miss_q;
    res_o.write_hit_count     = wr_hit_q;
    res_o.write_miss_count    = wr_miss_q;
    res_o.memory_access_count = mem_q;
  end

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  a_wb_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.writeback) |-> !res_o.hit)
    else $error("writeback reported on a hit");

  a_ev_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.writeback) |-> (res_o.evicted_tag == '0))
    else $error("evicted tag nonzero without writeback");

  a_mem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_q == CntW'(rd_miss_q + wr_miss_q))
    else $error("memory access count out of step with miss counts");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !res_valid_o))
    else $error("accepted access did not enter the lookup");

endmodule

FILE: tb/sv/set_assoc_cache_tag_lookup_test.sv
// self-checking testbench for set_assoc_cache_tag_lookup
// needs satl_pkg and the block's rtl; a scoreboard class predicts each access result
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_test;
  import satl_pkg::*;

  localparam int NUM_SETS   = 64;
  localparam int WAYS       = 4;
  localparam int SET_W      = $clog2(NUM_SETS);
  localparam int TAG_W      = ADDR_W - SET_W;
  localparam int LINES      = NUM_SETS * WAYS;
  localparam int STALL_MAX  = 4000;
  localparam int TAIL_WAIT  = 200;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  class access_scoreboard;
    bit                line_valid [LINES];
    bit                line_dirty [LINES];
    logic [TAG_W-1:0]  line_tag [LINES];
    logic [LFSR_W-1:0] victim_lfsr;
    logic [CNT_W-1:0]  read_hits;
    logic [CNT_W-1:0]  read_misses;
    logic [CNT_W-1:0]  write_hits;
    logic [CNT_W-1:0]  write_misses;
    logic [CNT_W-1:0]  memory_accesses;
    bit                write_back;
    res_t              expected_results[$];
    int                errors;

    function new();
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
      end
      victim_lfsr     = LFSR_SEED;
      read_hits       = '0;
      read_misses     = '0;
      write_hits      = '0;
      write_misses    = '0;
      memory_accesses = '0;
      write_back      = 1'b1;
      errors          = 0;
    endfunction

    function void set_write_back(bit v);
      write_back = v;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // one access beat: look up the set, update the store, queue the result
    function void note_access(req_t r);
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
      int               base;
      int               slot;
      bit               is_write;
      bit               hit;
      res_t             exp;
      set_idx  = r.address[SET_W-1:0];
      tag      = r.address[ADDR_W-1:SET_W];
      base     = int'(set_idx) * WAYS;
      is_write = (r.action == ACT_WRITE);
      hit      = 1'b0;
      exp      = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag) begin
          hit = 1'b1;
          if (is_write && write_back) begin
            line_dirty[base + w] = 1'b1;
          end
        end
      end
      if (hit) begin
        if (is_write) write_hits++;
        else read_hits++;
      end else begin
        if (is_write) write_misses++;
        else read_misses++;
        victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                       victim_lfsr[LFSR_W-1:1]};
        slot = base + int'(victim_lfsr % WAYS);
        if (write_back && line_dirty[slot]) begin
          exp.writeback   = 1'b1;
          exp.evicted_tag = line_tag[slot][EV_TAG_W-1:0];
        end
        line_tag[slot]   = tag;
        line_valid[slot] = 1'b1;
        line_dirty[slot] = is_write && write_back;
        memory_accesses++;
      end
      exp.hit                 = hit;
      exp.read_hit_count      = read_hits;
      exp.read_miss_count     = read_misses;
      exp.write_hit_count     = write_hits;
      exp.write_miss_count    = write_misses;
      exp.memory_access_count = memory_accesses;
      expected_results.push_back(exp);
    endfunction

    task check_field(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] exp);
      if (got !== exp) begin
        report_mismatch($sformatf("%s got %0h expected %0h", what, got, exp));
      end
    endtask

    task check_result(res_t got);
      res_t exp;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no pending access");
      end else begin
        exp = expected_results.pop_front();
        check_field("hit", CNT_W'(got.hit), CNT_W'(exp.hit));
        check_field("writeback", CNT_W'(got.writeback), CNT_W'(exp.writeback));
        check_field("evicted_tag", CNT_W'(got.evicted_tag), CNT_W'(exp.evicted_tag));
        check_field("read_hit_count", got.read_hit_count, exp.read_hit_count);
        check_field("read_miss_count", got.read_miss_count, exp.read_miss_count);
        check_field("write_hit_count", got.write_hit_count, exp.write_hit_count);
        check_field("write_miss_count", got.write_miss_count, exp.write_miss_count);
        check_field("memory_access_count", got.memory_access_count,
                    exp.memory_access_count);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  logic busy;
  req_t req_i       = '0;
  logic res_valid_o;
  res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i  = 1'b0;

  access_scoreboard sb = new();
  int               stall_cycles = 0;
  int               idle_pct = 0;
  logic [TAG_W-1:0] hot_tag [8];
  logic [SET_W-1:0] hot_set [4];

  set_assoc_cache_tag_lookup u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (start && !busy) begin
        sb.note_access(req_i);
      end
      if (res_valid_o) begin
        sb.check_result(res_o);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_write_back(cfg_data_i);
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(bit v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // drive one access beat and hold it until taken, then maybe leave a gap
  task automatic issue_access(logic [1:0] act, logic [ADDR_W-1:0] addr);
    req_t r;
    r.action  = act;
    r.address = addr;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
  endtask

  task automatic issue_random_access();
    int               pick;
    logic [1:0]       act;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 40) act = ACT_READ;
    else if (pick < 75) act = ACT_WRITE;
    else if (pick < 95) act = ACT_FETCH;
    else act = ACT_UNUSED;
    if ($urandom_range(0, 99) < 75) begin
      addr = {hot_tag[$urandom_range(0, 7)], hot_set[$urandom_range(0, 3)]};
    end else begin
      addr = $urandom;
    end
    issue_access(act, addr);
  endtask

  task automatic directed_accesses();
    issue_access(ACT_READ, 32'h0000_0000);
    issue_access(ACT_READ, 32'h0000_0000);
    issue_access(ACT_WRITE, 32'h0000_0000);
    issue_access(ACT_FETCH, 32'hFFFF_FFFF);
    issue_access(ACT_WRITE, 32'hFFFF_FFFF);
    issue_access(ACT_UNUSED, 32'hFFFF_FFFF);
    // overfill one set with writes so dirty victims get evicted
    for (int t = 1; t <= 8; t++) begin
      issue_access(ACT_WRITE, {TAG_W'(t), SET_W'(21)});
    end
    for (int t = 5; t <= 8; t++) begin
      issue_access(ACT_READ, {TAG_W'(t), SET_W'(21)});
    end
    issue_access(ACT_FETCH, 32'hAAAA_AAAA);
    issue_access(ACT_WRITE, 32'h5555_5555);
    issue_access(ACT_READ, 32'h5555_5555);
    issue_access(ACT_WRITE, {{TAG_W{1'b1}}, SET_W'(21)});
  endtask

  task automatic run_phase(bit wb, int pct, int n_items, bit with_directed);
    write_mode(wb);
    idle_pct = pct;
    foreach (hot_tag[i]) hot_tag[i] = TAG_W'($urandom);
    foreach (hot_set[i]) hot_set[i] = SET_W'($urandom);
    if (with_directed) directed_accesses();
    for (int i = 0; i < n_items; i++) issue_random_access();
    start <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(1'b1, 0, 190, 1'b1);
    run_phase(1'b0, 55, 190, 1'b0);
    run_phase(1'b1, 33, 190, 1'b0);
    run_phase(1'b0, 0, 190, 1'b0);
    run_phase(1'b1, 55, 190, 1'b0);
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/satl_pkg.sv
hw/rtl/satl_ram.sv
hw/rtl/satl_div.sv
hw/rtl/set_assoc_cache_tag_lookup.sv
tb/sv/set_assoc_cache_tag_lookup_test.sv
